[design/wheel_speed_pid_drive_defines.svh]
// Assertion helpers for the wheel speed drive block.
// They sample on the rising edge of clk and are off while rst is high.
`ifndef WHEEL_SPEED_PID_DRIVE_DEFINES_SVH
`define WHEEL_SPEED_PID_DRIVE_DEFINES_SVH

`define WSPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define WSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wspd_pkg.sv]
package wspd_pkg;

  localparam int GAIN_FRAC_BITS  = 16;
  localparam int SPEED_FRAC_BITS = 4;

  // Raw error is (|target| << 16) - (measured << (16 - SPEED_FRAC_BITS)).
  localparam int ERR_W   = ((32 - SPEED_FRAC_BITS) > 24 ? (32 - SPEED_FRAC_BITS) : 24) + 1;
  localparam int MA_W    = (ERR_W > 32) ? ERR_W : 32;
  localparam int MB_W    = 32;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int SUM_W   = PROD_W;
  localparam int SCALE_W = 21;
  localparam int E_W     = 32;
  localparam int ACC_W   = 48;
  localparam int COEF0_W = 26;
  localparam int COEF1_W = 27;
  localparam int ADDR_W  = 5;

  localparam logic [23:0] GAIN_P_RESET       = 24'd68813;
  localparam logic [23:0] GAIN_I_RESET       = 24'd16056;
  localparam logic [23:0] GAIN_D_RESET       = 24'd54395;
  localparam logic [7:0]  TRIP_LIMIT_RESET   = 8'd150;
  localparam logic [16:0] SCALE_OFFSET_RESET = 17'd69632;
  localparam logic [11:0] SCALE_SLOPE_RESET  = 12'd410;

  localparam logic signed [7:0] DRIVE_FWD_LO = -8'sd10;
  localparam logic signed [7:0] DRIVE_FWD_HI = 8'sd100;
  localparam logic signed [7:0] DRIVE_REV_LO = -8'sd100;
  localparam logic signed [7:0] DRIVE_REV_HI = 8'sd10;

  localparam logic [1:0] CMD_FORCE_ZERO = 2'd1;
  localparam logic [1:0] CMD_CLEAR_HIST = 2'd2;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_TRIP_LIMIT,
    REG_SCALE_OFFSET,
    REG_SCALE_SLOPE
  } reg_idx_t;

  typedef enum logic [3:0] {
    STEP_LATCH,
    STEP_CHECK,
    STEP_SCALE,
    STEP_ERR_MUL,
    STEP_ESAT,
    STEP_MUL0,
    STEP_MUL1,
    STEP_MUL2,
    STEP_ACC,
    STEP_SHIFT,
    STEP_UPDATE,
    STEP_NEG,
    STEP_DRIVE,
    STEP_EMIT
  } step_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_CHECK,
    DP_SCALE,
    DP_ESAT,
    DP_SHIFT,
    DP_UPDATE,
    DP_NEG,
    DP_DRIVE,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SLOPE_PX,
    MUL_ERR_SCALE,
    MUL_A0_E,
    MUL_A1_E1,
    MUL_A2_E2
  } mul_sel_t;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD
  } sum_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_TRIP,
    JMP_SPECIAL,
    JMP_WAIT_OUT,
    JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    dp_op_t   dp;
    mul_sel_t mul;
    sum_op_t  sum;
    jmp_t     jmp;
    step_t    target;
  } ctrl_word_t;

  // Microprogram for one control tick.
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t w;
    case (s)
      STEP_LATCH:   w = '{DP_LATCH,  MUL_NONE,      SUM_HOLD, JMP_WAIT_IN,  STEP_CHECK};
      STEP_CHECK:   w = '{DP_CHECK,  MUL_SLOPE_PX,  SUM_HOLD, JMP_TRIP,     STEP_EMIT};
      STEP_SCALE:   w = '{DP_SCALE,  MUL_NONE,      SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_ERR_MUL: w = '{DP_NONE,   MUL_ERR_SCALE, SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_ESAT:    w = '{DP_ESAT,   MUL_NONE,      SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_MUL0:    w = '{DP_NONE,   MUL_A0_E,      SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_MUL1:    w = '{DP_NONE,   MUL_A1_E1,     SUM_LOAD, JMP_NEXT,     STEP_LATCH};
      STEP_MUL2:    w = '{DP_NONE,   MUL_A2_E2,     SUM_ADD,  JMP_NEXT,     STEP_LATCH};
      STEP_ACC:     w = '{DP_NONE,   MUL_NONE,      SUM_ADD,  JMP_NEXT,     STEP_LATCH};
      STEP_SHIFT:   w = '{DP_SHIFT,  MUL_NONE,      SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_UPDATE:  w = '{DP_UPDATE, MUL_NONE,      SUM_HOLD, JMP_SPECIAL,  STEP_EMIT};
      STEP_NEG:     w = '{DP_NEG,    MUL_NONE,      SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_DRIVE:   w = '{DP_DRIVE,  MUL_NONE,      SUM_HOLD, JMP_NEXT,     STEP_LATCH};
      STEP_EMIT:    w = '{DP_EMIT,   MUL_NONE,      SUM_HOLD, JMP_WAIT_OUT, STEP_LATCH};
      default:      w = '{DP_NONE,   MUL_NONE,      SUM_HOLD, JMP_ALWAYS,   STEP_LATCH};
    endcase
    return w;
  endfunction

endpackage

[design/wheel_speed_pid_drive.sv]
// Normal tick: the input is latched, then the check, scale, error product, saturation,
// three coefficient products, accumulate, shift, update, negate, drive and emit steps
// follow; one shared multiplier forms five products in sequence under the microprogram.
// A trip jumps from the check step to emit, and commands 1 and 2 from update to emit.
// Synchronous reset loads the register defaults and clears the controller history;
// no clearing pass is needed.
`include "wheel_speed_pid_drive_defines.svh"

module wheel_speed_pid_drive
  import wspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [7:0]   target_speed,
  input  logic [15:0]         measured_speed,
  input  logic [1:0]          command,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [7:0]   drive,
  output logic                tripped,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers.
  logic [23:0] gain_p, gain_i, gain_d;
  logic [7:0]  trip_limit;
  logic [16:0] scale_offset;
  logic [11:0] scale_slope;

  logic [COEF0_W-1:0]        a0_reg;
  logic signed [COEF1_W-1:0] a1_reg;

  // Sequencer.
  step_t      pc, pc_next;
  ctrl_word_t cw;
  logic       out_free;

  // Latched tick inputs.
  logic signed [7:0] t_reg;
  logic [15:0]       meas_reg;
  logic [1:0]        cmd_reg;

  // Datapath registers.
  logic signed [ERR_W-1:0]   err_reg;
  logic signed [SCALE_W-1:0] scale_reg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   q_reg;
  logic signed [E_W-1:0]     e_reg;
  logic signed [7:0]         res_drive;
  logic                      res_tripped;

  // Controller state.
  logic signed [7:0]       previous_target;
  logic signed [E_W-1:0]   error_delay_one, error_delay_two;
  logic signed [ACC_W-1:0] pid_accumulator, signed_output;
  logic signed [7:0]       held_drive;

  // Combinational datapath.
  logic [7:0]                px;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [SCALE_W-1:0] scale_c;
  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic [ACC_W-1:0]          mag;
  logic                      trip;
  logic signed [PROD_W-1:0]  e_bias, e_sh;
  logic signed [E_W-1:0]     e_c;
  logic signed [SUM_W-1:0]   sum_bias, q_c;
  logic signed [SUM_W-1:0]   y_full;
  logic signed [ACC_W-1:0]   y_c, neg_c;
  logic signed [ACC_W-1:0]   v_bias, v;
  logic signed [7:0]         lo, hi, drive_c;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = (pc == STEP_LATCH);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RESET;
      gain_i       <= GAIN_I_RESET;
      gain_d       <= GAIN_D_RESET;
      trip_limit   <= TRIP_LIMIT_RESET;
      scale_offset <= SCALE_OFFSET_RESET;
      scale_slope  <= SCALE_SLOPE_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_GAIN_P:       gain_p       <= pwdata[23:0];
        REG_GAIN_I:       gain_i       <= pwdata[23:0];
        REG_GAIN_D:       gain_d       <= pwdata[23:0];
        REG_TRIP_LIMIT:   trip_limit   <= pwdata[7:0];
        REG_SCALE_OFFSET: scale_offset <= pwdata[16:0];
        REG_SCALE_SLOPE:  scale_slope  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_GAIN_P:       prdata = {8'd0, gain_p};
      REG_GAIN_I:       prdata = {8'd0, gain_i};
      REG_GAIN_D:       prdata = {8'd0, gain_d};
      REG_TRIP_LIMIT:   prdata = {24'd0, trip_limit};
      REG_SCALE_OFFSET: prdata = {15'd0, scale_offset};
      REG_SCALE_SLOPE:  prdata = {20'd0, scale_slope};
      default:          prdata = 32'd0;
    endcase
  end

  // The user must change the PID gains only while the block is idle; the block itself
  // does not enforce this. The coefficients are registered ahead of their first use.
  always_ff @(posedge clk) begin
    a0_reg <= {2'd0, gain_p} + {2'd0, gain_i} + {2'd0, gain_d};
    a1_reg <= -$signed({3'd0, gain_p} + {2'd0, gain_d, 1'b0});
  end

  // Control store and step counter.
  always_comb begin
    cw = ucode(pc);
  end

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:     pc_next = step_t'(pc + 4'd1);
      JMP_WAIT_IN:  pc_next = in_valid ? step_t'(pc + 4'd1) : pc;
      JMP_TRIP:     pc_next = trip ? cw.target : step_t'(pc + 4'd1);
      JMP_SPECIAL:  pc_next = (cmd_reg == CMD_FORCE_ZERO || cmd_reg == CMD_CLEAR_HIST)
                              ? cw.target : step_t'(pc + 4'd1);
      JMP_WAIT_OUT: pc_next = out_free ? cw.target : pc;
      JMP_ALWAYS:   pc_next = cw.target;
      default:      pc_next = STEP_LATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LATCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Combinational datapath.
  always_comb begin
    px    = t_reg[7] ? (~t_reg + 8'd1) : t_reg;
    err_c = $signed({{(ERR_W - 24){1'b0}}, px, 16'd0})
          - $signed({{(ERR_W - (32 - SPEED_FRAC_BITS)){1'b0}}, meas_reg,
                     {(16 - SPEED_FRAC_BITS){1'b0}}});

    // The slope product stays below 2^20, so its low bits carry the full value.
    scale_c = $signed({4'd0, scale_offset}) - $signed({1'b0, prod[19:0]});

    mag  = signed_output[ACC_W-1] ? -signed_output : signed_output;
    trip = (previous_target < 0 && t_reg > 0) || (previous_target > 0 && t_reg < 0)
        || (t_reg == 8'sd0) || (mag > {24'd0, trip_limit, 16'd0});

    // Shifts that truncate toward zero add a bias below the cut for negative values.
    e_bias = prod + $signed({{(PROD_W - 16){1'b0}}, {16{prod[PROD_W-1]}}});
    e_sh   = e_bias >>> 16;
    if (&e_sh[PROD_W-1:E_W-1] || ~|e_sh[PROD_W-1:E_W-1]) begin
      e_c = e_sh[E_W-1:0];
    end else begin
      e_c = e_sh[PROD_W-1] ? $signed({1'b1, {(E_W-1){1'b0}}})
                           : $signed({1'b0, {(E_W-1){1'b1}}});
    end

    sum_bias = sum + $signed({{(SUM_W - GAIN_FRAC_BITS){1'b0}},
                              {GAIN_FRAC_BITS{sum[SUM_W-1]}}});
    q_c      = sum_bias >>> GAIN_FRAC_BITS;

    y_full = q_reg + SUM_W'(pid_accumulator);
    if (&y_full[SUM_W-1:ACC_W-1] || ~|y_full[SUM_W-1:ACC_W-1]) begin
      y_c = y_full[ACC_W-1:0];
    end else begin
      y_c = y_full[SUM_W-1] ? $signed({1'b1, {(ACC_W-1){1'b0}}})
                            : $signed({1'b0, {(ACC_W-1){1'b1}}});
    end

    neg_c = (signed_output == $signed({1'b1, {(ACC_W-1){1'b0}}}))
          ? $signed({1'b0, {(ACC_W-1){1'b1}}}) : -signed_output;

    v_bias = signed_output + $signed({{(ACC_W - 16){1'b0}}, {16{signed_output[ACC_W-1]}}});
    v      = v_bias >>> 16;
    lo     = t_reg[7] ? DRIVE_REV_LO : DRIVE_FWD_LO;
    hi     = t_reg[7] ? DRIVE_REV_HI : DRIVE_FWD_HI;
    if (v < ACC_W'(lo)) begin
      drive_c = lo;
    end else if (v > ACC_W'(hi)) begin
      drive_c = hi;
    end else begin
      drive_c = v[7:0];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cw.mul)
      MUL_SLOPE_PX: begin
        ma = $signed({{(MA_W - 8){1'b0}}, px});
        mb = $signed({{(MB_W - 12){1'b0}}, scale_slope});
      end
      MUL_ERR_SCALE: begin
        ma = MA_W'(err_reg);
        mb = MB_W'(scale_reg);
      end
      MUL_A0_E: begin
        ma = MA_W'(e_reg);
        mb = $signed({{(MB_W - COEF0_W){1'b0}}, a0_reg});
      end
      MUL_A1_E1: begin
        ma = MA_W'(error_delay_one);
        mb = MB_W'(a1_reg);
      end
      MUL_A2_E2: begin
        ma = MA_W'(error_delay_two);
        mb = $signed({{(MB_W - 24){1'b0}}, gain_d});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cw.sum)
      SUM_LOAD: sum <= prod;
      SUM_ADD:  sum <= sum + prod;
      default:  sum <= sum;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cw.dp)
      DP_LATCH: begin
        t_reg    <= target_speed;
        meas_reg <= measured_speed;
        cmd_reg  <= command;
      end
      DP_CHECK: begin
        err_reg <= err_c;
        if (trip) begin
          res_drive   <= 8'sd0;
          res_tripped <= 1'b1;
        end
      end
      DP_SCALE: scale_reg <= scale_c;
      DP_ESAT:  e_reg     <= e_c;
      DP_SHIFT: q_reg     <= q_c;
      DP_UPDATE: begin
        res_tripped <= 1'b0;
        if (cmd_reg == CMD_FORCE_ZERO) begin
          res_drive <= 8'sd0;
        end else if (cmd_reg == CMD_CLEAR_HIST) begin
          res_drive <= held_drive;
        end
      end
      DP_DRIVE: res_drive <= drive_c;
      default: ;
    endcase
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_target <= 8'sd0;
      error_delay_one <= '0;
      error_delay_two <= '0;
      pid_accumulator <= '0;
      signed_output   <= '0;
      held_drive      <= 8'sd0;
    end else begin
      case (cw.dp)
        DP_CHECK: begin
          previous_target <= t_reg;
          if (trip) begin
            error_delay_one <= '0;
            error_delay_two <= '0;
            pid_accumulator <= '0;
            signed_output   <= '0;
            held_drive      <= 8'sd0;
          end
        end
        DP_UPDATE: begin
          signed_output <= y_c;
          if (cmd_reg == CMD_CLEAR_HIST) begin
            error_delay_one <= '0;
            error_delay_two <= '0;
            pid_accumulator <= '0;
          end else begin
            error_delay_two <= error_delay_one;
            error_delay_one <= e_reg;
            pid_accumulator <= y_c;
          end
          if (cmd_reg == CMD_FORCE_ZERO) begin
            held_drive <= 8'sd0;
          end
        end
        DP_NEG: begin
          if (t_reg[7]) begin
            signed_output <= neg_c;
          end
        end
        DP_DRIVE: held_drive <= drive_c;
        default: ;
      endcase
    end
  end

  // Output register; the next tick may be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.dp == DP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.dp == DP_EMIT && out_free) begin
      drive   <= res_drive;
      tripped <= res_tripped;
    end
  end

  `WSPD_ASSERT_NEXT(a_accept_starts_check, in_valid && in_ready, pc == STEP_CHECK,
                    "input transaction did not start the check step")
  `WSPD_ASSERT_NEXT(a_trip_clears_state, pc == STEP_CHECK && trip,
                    pid_accumulator == '0 && signed_output == '0 && pc == STEP_EMIT,
                    "trip did not clear the controller state")
  `WSPD_ASSERT_SAME(a_load_from_emit, $rose(out_valid), $past(pc) == STEP_EMIT,
                    "result loaded outside the emit step")
  `WSPD_ASSERT_SAME(a_trip_drives_zero, out_valid && tripped, drive == 8'sd0,
                    "tripped result with nonzero drive")
  `WSPD_ASSERT_SAME(a_drive_in_range, out_valid, drive >= -8'sd100 && drive <= 8'sd100,
                    "drive outside its clamp range")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import wspd_pkg::*;

  // The package names only the two special commands.
  localparam logic [1:0] CMD_NORMAL = 2'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [7:0] drive_level;
    logic              trip_flag;
  } drive_result_t;

  class drive_tracker;
    logic [23:0] kp, ki, kd;
    logic [7:0]  trip_lim;
    logic [16:0] sc_off;
    logic [11:0] sc_slope;
    logic signed [7:0] last_target;
    logic signed [7:0] held;
    longint err_d1, err_d2, acc, out_q16;
    drive_result_t expected_drives[$];
    int mismatches;

    function new();
      kp = GAIN_P_RESET;
      ki = GAIN_I_RESET;
      kd = GAIN_D_RESET;
      trip_lim = TRIP_LIMIT_RESET;
      sc_off = SCALE_OFFSET_RESET;
      sc_slope = SCALE_SLOPE_RESET;
      last_target = 0;
      held = 0;
      err_d1 = 0;
      err_d2 = 0;
      acc = 0;
      out_q16 = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_GAIN_P:       kp = value[23:0];
        REG_GAIN_I:       ki = value[23:0];
        REG_GAIN_D:       kd = value[23:0];
        REG_TRIP_LIMIT:   trip_lim = value[7:0];
        REG_SCALE_OFFSET: sc_off = value[16:0];
        REG_SCALE_SLOPE:  sc_slope = value[11:0];
        default: ;
      endcase
    endfunction

    // Arithmetic shift that rounds toward zero instead of toward minus infinity.
    function longint trunc_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
    endfunction

    function longint saturate(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void note_tick(logic signed [7:0] t, logic [15:0] m, logic [1:0] c);
      longint px, err, scale, e, a0, a1, a2, sum, y, mag, v, lo, hi;
      logic flip;
      drive_result_t r;
      mag = (out_q16 < 0) ? -out_q16 : out_q16;
      flip = (last_target < 0 && t > 0) || (last_target > 0 && t < 0);
      if (flip || t == 0 || mag > (longint'(trip_lim) <<< 16)) begin
        last_target = t;
        err_d1 = 0;
        err_d2 = 0;
        acc = 0;
        out_q16 = 0;
        held = 0;
        r.drive_level = 0;
        r.trip_flag = 1'b1;
        expected_drives.push_back(r);
        return;
      end
      last_target = t;
      // Widen before negating so that -128 keeps its magnitude.
      px = longint'(t);
      if (px < 0) px = -px;
      err = (px <<< 16) - (longint'(m) <<< (16 - SPEED_FRAC_BITS));
      scale = longint'(sc_off) - longint'(sc_slope) * px;
      e = saturate(trunc_shift(err * scale, 16), 32);
      a0 = longint'(kp) + longint'(ki) + longint'(kd);
      a1 = -(longint'(kp) + 2 * longint'(kd));
      a2 = longint'(kd);
      sum = a0 * e + a1 * err_d1 + a2 * err_d2;
      y = saturate(acc + trunc_shift(sum, GAIN_FRAC_BITS), 48);
      err_d2 = err_d1;
      err_d1 = e;
      acc = y;
      out_q16 = y;
      r.trip_flag = 1'b0;
      case (c)
        CMD_FORCE_ZERO: begin
          held = 0;
          r.drive_level = 0;
        end
        CMD_CLEAR_HIST: begin
          err_d1 = 0;
          err_d2 = 0;
          acc = 0;
          r.drive_level = held;
        end
        default: begin
          if (t < 0) begin
            out_q16 = saturate(-y, 48);
            lo = DRIVE_REV_LO;
            hi = DRIVE_REV_HI;
          end else begin
            lo = DRIVE_FWD_LO;
            hi = DRIVE_FWD_HI;
          end
          v = trunc_shift(out_q16, 16);
          if (v < lo) v = lo;
          if (v > hi) v = hi;
          r.drive_level = v[7:0];
          held = r.drive_level;
        end
      endcase
      expected_drives.push_back(r);
    endfunction

    function void check_drive(logic signed [7:0] d, logic tr);
      drive_result_t r;
      if (expected_drives.size() == 0) begin
        $error("drive transaction with no tick pending: drive %0d, tripped %0d", d, tr);
        mismatches++;
        return;
      end
      r = expected_drives.pop_front();
      if (d !== r.drive_level) begin
        $error("drive mismatch: expected %0d, actual %0d", r.drive_level, d);
        mismatches++;
      end
      if (tr !== r.trip_flag) begin
        $error("tripped mismatch: expected %0d, actual %0d", r.trip_flag, tr);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic signed [7:0]   target_speed;
  logic [15:0]         measured_speed;
  logic [1:0]          command;
  logic                out_valid;
  logic                out_ready;
  logic signed [7:0]   drive;
  logic                tripped;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bit no_gaps;
  bit hold_req;
  drive_tracker sb = new();

  wheel_speed_pid_drive u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .target_speed  (target_speed),
    .measured_speed(measured_speed),
    .command       (command),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive         (drive),
    .tripped       (tripped),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the register write.
  // The caller drops psel once its last write is done.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] p, input logic [31:0] i,
                               input logic [31:0] d, input logic [31:0] trip,
                               input logic [31:0] offset, input logic [31:0] slope);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_TRIP_LIMIT, trip);
    write_reg(REG_SCALE_OFFSET, offset);
    write_reg(REG_SCALE_SLOPE, slope);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_tick(input logic signed [7:0] t, input logic [15:0] m,
                           input logic [1:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    target_speed <= t;
    measured_speed <= m;
    command <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t, m, c);
    @(negedge clk);
  endtask

  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly runs of one direction with a measured speed near the target, so the
  // controller settles and integrates; the rest are trips, odd targets and noise.
  task automatic run_random(input int n);
    int k, r, mag, meas;
    bit reverse;
    logic signed [7:0] t;
    logic [15:0] m;
    logic [1:0] c;
    reverse = 1'($urandom_range(0, 1));
    for (k = 0; k < n; k++) begin
      no_gaps = (k >= n / 3) && (k < n / 2);
      if ($urandom_range(0, 24) == 0) reverse = !reverse;
      mag = $urandom_range(1, 100);
      r = $urandom_range(0, 99);
      if (r < 4) t = 0;
      else if (r < 8) t = 8'($urandom);
      else if (r < 10) t = -8'sd128;
      else t = reverse ? 8'(-mag) : 8'(mag);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        meas = mag * 16 + $urandom_range(0, 96) - 48;
        if (meas < 0) meas = 0;
        m = 16'(meas);
      end else begin
        m = 16'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 82) c = CMD_NORMAL;
      else if (r < 88) c = CMD_FORCE_ZERO;
      else if (r < 94) c = CMD_CLEAR_HIST;
      else c = CMD_UNUSED;
      send_tick(t, m, c);
    end
    no_gaps = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_drive(drive, tripped);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    target_speed = 0;
    measured_speed = 0;
    command = CMD_NORMAL;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks on the reset gains.
    send_tick(0, 0, CMD_NORMAL);
    send_tick(40, 640, CMD_NORMAL);
    send_tick(40, 0, CMD_NORMAL);
    send_tick(40, 16'hFFFF, CMD_NORMAL);
    send_tick(40, 16'hFFFF, CMD_NORMAL);
    send_tick(40, 600, CMD_NORMAL);
    send_tick(100, 1600, CMD_FORCE_ZERO);
    send_tick(100, 1500, CMD_CLEAR_HIST);
    send_tick(100, 1550, CMD_UNUSED);
    send_tick(-30, 480, CMD_NORMAL);
    send_tick(-30, 400, CMD_NORMAL);
    send_tick(-30, 0, CMD_NORMAL);
    send_tick(-128, 0, CMD_NORMAL);
    send_tick(-128, 2048, CMD_CLEAR_HIST);
    send_tick(127, 2032, CMD_NORMAL);
    send_tick(127, 0, CMD_NORMAL);
    send_tick(127, 16'hFFFF, CMD_FORCE_ZERO);
    send_tick(1, 16, CMD_NORMAL);
    send_tick(-100, 16'hFFFF, CMD_NORMAL);
    send_tick(-100, 16'hFFFF, CMD_NORMAL);
    send_tick(-100, 16'hFFFF, CMD_NORMAL);
    send_tick(-1, 0, CMD_UNUSED);
    run_random(130);
    drain_ticks();

    // Every register at its top value; the scale goes negative for larger targets.
    apply_setting(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0000_00FF,
                  32'h0001_FFFF, 32'h0000_0FFF);
    hold_req = 1'b1;
    run_random(130);
    drain_ticks();

    apply_setting(0, 0, 0, 0, 0, 0);
    run_random(130);
    drain_ticks();

    apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(130);
    drain_ticks();

    // Small offset against a steep slope makes the scale negative for most targets.
    apply_setting($urandom_range(0, 200000), $urandom_range(0, 50000),
                  $urandom_range(0, 100000), $urandom_range(0, 255),
                  $urandom_range(0, 20000), $urandom_range(2000, 4095));
    run_random(130);
    drain_ticks();

    apply_setting($urandom_range(30000, 100000), $urandom_range(5000, 30000),
                  $urandom_range(20000, 80000), $urandom_range(50, 255),
                  $urandom_range(60000, 80000), $urandom_range(200, 600));
    run_random(130);
    drain_ticks();

    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
